@@ rtl/core/linear_flash_command_interface_defines.svh @@
// Assertion macros shared by the checker files of the flash command interface.
// Each macro expects signals named clk and rst_n in the enclosing scope.
`ifndef LINEAR_FLASH_COMMAND_INTERFACE_DEFINES_SVH
`define LINEAR_FLASH_COMMAND_INTERFACE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LFCI_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("flash command interface check failed");

// Next-cycle implication, disabled while reset is asserted.
`define LFCI_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("flash command interface check failed");

`endif

@@ rtl/core/lfci_pkg.sv @@
package lfci_pkg;

    localparam int ADDR_IN_W = 21;
    localparam int EADDR_W   = 22;
    localparam int CARD_W    = 22;
    localparam int WORD_W    = 32;

    localparam int S_TDATA_W = 56;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 40;

    localparam logic [CARD_W-1:0] CARD_RESET = 22'd2097152;

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;
    localparam int Q_CNT_W = 2;

    // Command words and bytes.
    localparam logic [31:0] CMD_W_READ    = 32'hFFFF_0000;
    localparam logic [31:0] CMD_W_CLEAR   = 32'h5050_0000;
    localparam logic [31:0] CMD_W_STATUS  = 32'h7070_0000;
    localparam logic [31:0] CMD_W_PROGRAM = 32'h4040_0000;
    localparam logic [31:0] CMD_W_ERASE   = 32'h2020_0000;
    localparam logic [31:0] CMD_W_CONFIRM = 32'hD0D0_0000;
    localparam logic [7:0]  CMD_B_READ    = 8'hFF;
    localparam logic [7:0]  CMD_B_CLEAR   = 8'h50;
    localparam logic [7:0]  CMD_B_STATUS  = 8'h70;
    localparam logic [7:0]  CMD_B_PROGRAM = 8'h40;
    localparam logic [7:0]  CMD_B_ERASE   = 8'h20;
    localparam logic [7:0]  CMD_B_CONFIRM = 8'hD0;

    localparam logic [7:0] STAT_READY = 8'h80;
    localparam logic [7:0] STAT_ERROR = 8'hB0;
    localparam logic [7:0] ERASED     = 8'hFF;

    typedef enum logic [1:0] {
        MODE_READ    = 2'd0,
        MODE_STATUS  = 2'd1,
        MODE_PROGRAM = 2'd2,
        MODE_ERASE   = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        REQ_RD_WORD = 2'd0,
        REQ_RD_BYTE = 2'd1,
        REQ_WR_WORD = 2'd2,
        REQ_WR_BYTE = 2'd3
    } req_t;

    typedef enum logic [2:0] {
        K_RD_WORD = 3'd0,
        K_RD_BYTE = 3'd1,
        K_WRITE   = 3'd2,
        K_ERASE   = 3'd3,
        K_CONST   = 3'd4
    } kind_t;

    // mask: byte slots for reads and writes (slot 0 at addr), lanes for erase.
    // data: bytes to program (slot 0 in the top byte) or the finished result.
    typedef struct packed {
        kind_t               kind;
        logic [EADDR_W-1:0]  addr;
        logic [3:0]          mask;
        logic [WORD_W-1:0]   data;
        mode_t               mode;
    } entry_t;

endpackage

@@ rtl/core/lfci_front.sv @@
module lfci_front #(
    parameter int ADDR_BITS = 21
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [lfci_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    input  logic [lfci_pkg::S_TUSER_W-1:0]    s_axis_tuser,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [lfci_pkg::CARD_W-1:0]       cfg_data,
    input  logic                              q_full,
    input  logic                              clearing,
    output logic                              q_push,
    output lfci_pkg::entry_t                  q_entry
);

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_READ,
        CMD_CLEAR,
        CMD_STATUS,
        CMD_PROGRAM,
        CMD_ERASE
    } cmd_t;

    function automatic cmd_t decode_cmd(input logic [31:0] v, input logic word);
        cmd_t c;
        c = CMD_NONE;
        if (word)
        begin
            if (v == lfci_pkg::CMD_W_READ)         c = CMD_READ;
            else if (v == lfci_pkg::CMD_W_CLEAR)   c = CMD_CLEAR;
            else if (v == lfci_pkg::CMD_W_STATUS)  c = CMD_STATUS;
            else if (v == lfci_pkg::CMD_W_PROGRAM) c = CMD_PROGRAM;
            else if (v == lfci_pkg::CMD_W_ERASE)   c = CMD_ERASE;
        end
        else
        begin
            if (v[7:0] == lfci_pkg::CMD_B_READ)         c = CMD_READ;
            else if (v[7:0] == lfci_pkg::CMD_B_CLEAR)   c = CMD_CLEAR;
            else if (v[7:0] == lfci_pkg::CMD_B_STATUS)  c = CMD_STATUS;
            else if (v[7:0] == lfci_pkg::CMD_B_PROGRAM) c = CMD_PROGRAM;
            else if (v[7:0] == lfci_pkg::CMD_B_ERASE)   c = CMD_ERASE;
        end
        return c;
    endfunction

    lfci_pkg::mode_t                mode_reg, mode_next;
    logic [7:0]                     status_reg, status_next;
    logic [lfci_pkg::CARD_W-1:0]    card_reg;

    lfci_pkg::req_t                 req;
    logic [lfci_pkg::ADDR_IN_W-1:0] addr_in;
    logic [31:0]                    wval;
    logic                           upper;
    logic                           word;
    logic                           confirm;
    logic [lfci_pkg::EADDR_W-1:0]   a_ext [4];
    logic [3:0]                     ok;
    cmd_t                           cmd;
    logic                           accept;

    assign accept        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = !q_full && !clearing;
    assign q_push        = accept;
    assign cfg_ready     = 1'b1;

    always_comb
    begin
        req     = lfci_pkg::req_t'(s_axis_tuser[1:0]);
        upper   = s_axis_tuser[2];
        addr_in = s_axis_tdata[20:0];
        wval    = s_axis_tdata[52:21];
        word    = (req == lfci_pkg::REQ_WR_WORD);
        cmd     = decode_cmd(wval, word);
        confirm = word ? (wval == lfci_pkg::CMD_W_CONFIRM)
                       : (wval[7:0] == lfci_pkg::CMD_B_CONFIRM);

        // A byte reads as zero at or beyond the card size or beyond the array.
        for (int i = 0; i < 4; i++)
        begin
            a_ext[i] = {1'b0, addr_in} + lfci_pkg::EADDR_W'(i);
            ok[i]    = (a_ext[i] < card_reg) && ((a_ext[i] >> ADDR_BITS) == '0);
        end

        mode_next     = mode_reg;
        status_next   = status_reg;
        q_entry.kind  = lfci_pkg::K_CONST;
        q_entry.addr  = {1'b0, addr_in};
        q_entry.mask  = 4'b0000;
        q_entry.data  = '0;

        unique case (req)
            lfci_pkg::REQ_RD_WORD:
            begin
                if (mode_reg == lfci_pkg::MODE_READ)
                begin
                    q_entry.kind = lfci_pkg::K_RD_WORD;
                    q_entry.mask = ok;
                end
                else
                begin
                    q_entry.data = {status_reg, status_reg, 16'h0000};
                end
            end
            lfci_pkg::REQ_RD_BYTE:
            begin
                if (mode_reg == lfci_pkg::MODE_READ)
                begin
                    q_entry.kind = lfci_pkg::K_RD_BYTE;
                    q_entry.mask = {3'b000, ok[0]};
                end
                else
                begin
                    q_entry.data = {24'h000000, status_reg};
                end
            end
            lfci_pkg::REQ_WR_WORD, lfci_pkg::REQ_WR_BYTE:
            begin
                if (mode_reg == lfci_pkg::MODE_PROGRAM)
                begin
                    q_entry.kind = lfci_pkg::K_WRITE;
                    if (word)
                    begin
                        q_entry.addr = upper ? a_ext[2] : a_ext[0];
                        q_entry.data = {wval[31:16], 16'h0000};
                        q_entry.mask = 4'b0011;
                    end
                    else
                    begin
                        q_entry.data = {wval[7:0], 24'h000000};
                        q_entry.mask = 4'b0001;
                    end
                    mode_next = lfci_pkg::MODE_STATUS;
                end
                else if (mode_reg == lfci_pkg::MODE_ERASE)
                begin
                    if (confirm)
                    begin
                        q_entry.kind = lfci_pkg::K_ERASE;
                        // A byte erase touches only the lanes of the address parity.
                        q_entry.mask = word ? 4'b1111 : (addr_in[0] ? 4'b1010 : 4'b0101);
                        status_next  = lfci_pkg::STAT_READY;
                    end
                    else
                    begin
                        status_next = lfci_pkg::STAT_ERROR;
                    end
                    mode_next = lfci_pkg::MODE_STATUS;
                end
                else
                begin
                    unique case (cmd)
                        CMD_READ:    mode_next   = lfci_pkg::MODE_READ;
                        CMD_CLEAR:   status_next = lfci_pkg::STAT_READY;
                        CMD_STATUS:  mode_next   = lfci_pkg::MODE_STATUS;
                        CMD_PROGRAM: mode_next   = lfci_pkg::MODE_PROGRAM;
                        CMD_ERASE:   mode_next   = lfci_pkg::MODE_ERASE;
                        default:     mode_next   = mode_reg;
                    endcase
                end
            end
            default:
            begin
                mode_next = mode_reg;
            end
        endcase

        q_entry.mode = mode_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= lfci_pkg::MODE_READ;
            status_reg <= lfci_pkg::STAT_READY;
            card_reg   <= lfci_pkg::CARD_RESET;
        end
        else
        begin
            if (accept)
            begin
                mode_reg   <= mode_next;
                status_reg <= status_next;
            end
            if (cfg_valid && cfg_ready)
            begin
                card_reg <= cfg_data;
            end
        end
    end

endmodule

@@ rtl/core/lfci_queue.sv @@
module lfci_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  lfci_pkg::entry_t  push_entry,
    output logic              full,
    input  logic              pop,
    output logic              head_valid,
    output lfci_pkg::entry_t  head
);

    lfci_pkg::entry_t              slot_reg [lfci_pkg::Q_DEPTH];
    logic [lfci_pkg::Q_PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [lfci_pkg::Q_PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [lfci_pkg::Q_CNT_W-1:0]  count_reg, count_next;

    assign full       = (count_reg == lfci_pkg::Q_CNT_W'(lfci_pkg::Q_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + lfci_pkg::Q_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + lfci_pkg::Q_PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + lfci_pkg::Q_CNT_W'(push) - lfci_pkg::Q_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

@@ rtl/core/lfci_back.sv @@
module lfci_back #(
    parameter int ADDR_BITS         = 21,
    parameter int ERASE_BLOCK_BYTES = 131072
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            head_valid,
    input  lfci_pkg::entry_t                head,
    output logic                            pop,
    output logic                            clearing,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [lfci_pkg::M_TDATA_W-1:0]  m_axis_tdata
);

    localparam int ROW_BITS   = ADDR_BITS - 2;
    localparam int ROWS       = 2 ** ROW_BITS;
    localparam int SPAN       = (ERASE_BLOCK_BYTES < 2 ** ADDR_BITS) ?
                                ERASE_BLOCK_BYTES : 2 ** ADDR_BITS;
    localparam int ERASE_ROWS = SPAN / 4;
    localparam int ECNT_W     = $clog2(ERASE_ROWS);
    localparam logic [lfci_pkg::EADDR_W-1:0] ERASE_KEEP =
        ~lfci_pkg::EADDR_W'(ERASE_BLOCK_BYTES - 1);

    typedef enum logic [3:0] {
        ST_CLEAR = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_ERASE = 4'b0100,
        ST_DONE  = 4'b1000
    } state_t;

    state_t                 state_reg, state_next;
    logic [ROW_BITS-1:0]    row_reg, row_next;
    logic [ECNT_W-1:0]      cnt_reg, cnt_next;
    lfci_pkg::entry_t       cur_reg, cur_next;
    logic                   out_valid_reg, out_valid_next;
    logic [31:0]            out_data_reg, out_data_next;
    lfci_pkg::mode_t        out_mode_reg, out_mode_next;

    logic [ADDR_BITS-1:0]   head_addr;
    logic [ADDR_BITS-1:0]   erase_start;
    logic [1:0]             lane_idx [4];
    logic [ROW_BITS-1:0]    lane_row [4];
    logic [7:0]             lane_wbyte [4];
    logic [3:0]             lane_wen;

    logic [ROW_BITS-1:0]    mem_addr [4];
    logic [7:0]             mem_wd [4];
    logic [3:0]             mem_we;
    logic                   mem_re;
    logic [7:0]             lane_q [4];

    logic [7:0]             rb [4];
    logic [31:0]            result;
    logic                   out_free;

    assign clearing      = (state_reg == ST_CLEAR);
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'b000000, out_mode_reg, out_data_reg};

    // Each byte address maps to lane addr[1:0] and row addr[top:2]; an access
    // that crosses a row boundary reads the next row in the lower lanes.
    always_comb
    begin
        head_addr   = ADDR_BITS'(head.addr);
        erase_start = ADDR_BITS'(head.addr & ERASE_KEEP);
        for (int l = 0; l < 4; l++)
        begin
            lane_idx[l]   = 2'(2'(l) - head_addr[1:0]);
            lane_row[l]   = head_addr[ADDR_BITS-1:2] + ROW_BITS'(2'(l) < head_addr[1:0]);
            lane_wbyte[l] = 8'(head.data >> {~lane_idx[l], 3'b000});
            lane_wen[l]   = head.mask[lane_idx[l]];
        end
    end

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            rb[i] = cur_reg.mask[i] ? lane_q[2'(cur_reg.addr[1:0] + 2'(i))] : 8'h00;
        end
        unique case (cur_reg.kind)
            lfci_pkg::K_RD_WORD: result = {rb[0], rb[1], rb[2], rb[3]};
            lfci_pkg::K_RD_BYTE: result = {24'h000000, rb[0]};
            lfci_pkg::K_CONST:   result = cur_reg.data;
            default:             result = 32'h0000_0000;
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        row_next       = row_reg;
        cnt_next       = cnt_reg;
        cur_next       = cur_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_data_next  = out_data_reg;
        out_mode_next  = out_mode_reg;
        pop            = 1'b0;
        mem_re         = 1'b0;
        mem_we         = 4'b0000;
        for (int l = 0; l < 4; l++)
        begin
            mem_addr[l] = lane_row[l];
            mem_wd[l]   = lane_wbyte[l];
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we = 4'b1111;
                for (int l = 0; l < 4; l++)
                begin
                    mem_addr[l] = row_reg;
                    mem_wd[l]   = lfci_pkg::ERASED;
                end
                row_next = row_reg + ROW_BITS'(1);
                if (row_reg == '1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (head_valid)
                begin
                    pop      = 1'b1;
                    cur_next = head;
                    unique case (head.kind) inside
                        lfci_pkg::K_RD_WORD, lfci_pkg::K_RD_BYTE:
                        begin
                            mem_re     = 1'b1;
                            state_next = ST_DONE;
                        end
                        lfci_pkg::K_WRITE:
                        begin
                            mem_we     = lane_wen;
                            state_next = ST_DONE;
                        end
                        lfci_pkg::K_ERASE:
                        begin
                            row_next   = erase_start[ADDR_BITS-1:2];
                            cnt_next   = ECNT_W'(ERASE_ROWS - 1);
                            state_next = ST_ERASE;
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_ERASE:
            begin
                mem_we = cur_reg.mask;
                for (int l = 0; l < 4; l++)
                begin
                    mem_addr[l] = row_reg;
                    mem_wd[l]   = lfci_pkg::ERASED;
                end
                row_next = row_reg + ROW_BITS'(1);
                cnt_next = cnt_reg - ECNT_W'(1);
                if (cnt_reg == '0)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = result;
                    out_mode_next  = cur_reg.mode;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    for (genvar g = 0; g < 4; g++)
    begin : g_lane
        logic [7:0] mem [ROWS];

        always_ff @(posedge clk)
        begin
            if (mem_we[g])
            begin
                mem[mem_addr[g]] <= mem_wd[g];
            end
            else if (mem_re)
            begin
                lane_q[g] <= mem[mem_addr[g]];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            row_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            row_reg       <= row_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        out_data_reg <= out_data_next;
        out_mode_reg <= out_mode_next;
    end

endmodule

@@ rtl/core/linear_flash_command_interface.sv @@
// Command interface of a linear flash card behind a request stream.
// Requests arrive on s_axis: tuser holds req_type and upper_half_lane, tdata
// holds address and write_value. Each request gives exactly one response on
// m_axis: tdata holds read_data and mode_now. card_bytes is loaded through the
// cfg channel, which is always ready; write it only while no request is open.
// A front stage decodes commands and tracks mode and status, a two-entry queue
// holds decoded operations, and a back stage owns the byte array, held as four
// byte lanes of 2^(ADDR_BITS-2) rows each.
// Reads, programs and commands pass the back stage through its idle and done
// states; a response goes through the queue and the output register on its way
// to m_axis. An erase walks one row of four lanes per cycle, through
// min(ERASE_BLOCK_BYTES, 2^ADDR_BITS)/4 rows in all.
// After reset the back stage writes 0xFF through all 2^(ADDR_BITS-2) rows,
// and s_axis_tready stays low until it is done.
// While m_axis is stalled the response holds in its output register, the
// back stage waits with the next result, and the queue fills before the input
// side stops.
module linear_flash_command_interface #(
    parameter int ADDR_BITS         = 21,
    parameter int ERASE_BLOCK_BYTES = 131072
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,   // address[20:0], write_value[52:21]
    input  logic [2:0]  s_axis_tuser,   // req_type[1:0], upper_half_lane[2]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // read_data[31:0], mode_now[33:32]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [21:0] cfg_data        // card_bytes
);

    lfci_pkg::entry_t push_entry;
    lfci_pkg::entry_t head;
    logic             push;
    logic             full;
    logic             pop;
    logic             head_valid;
    logic             clearing;

    lfci_front #(
        .ADDR_BITS (ADDR_BITS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .q_full        (full),
        .clearing      (clearing),
        .q_push        (push),
        .q_entry       (push_entry)
    );

    lfci_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    lfci_back #(
        .ADDR_BITS         (ADDR_BITS),
        .ERASE_BLOCK_BYTES (ERASE_BLOCK_BYTES)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_valid    (head_valid),
        .head          (head),
        .pop           (pop),
        .clearing      (clearing),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

@@ rtl/core/lfci_checker.sv @@
`include "linear_flash_command_interface_defines.svh"

module lfci_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata
);

    logic [2:0] pend_reg;
    logic       in_xfer;
    logic       out_xfer;

    assign in_xfer  = s_axis_tvalid && s_axis_tready;
    assign out_xfer = m_axis_tvalid && m_axis_tready;

    // Requests taken but not yet answered.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_reg + 3'(in_xfer) - 3'(out_xfer);
        end
    end

    `LFCI_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
    `LFCI_ASSERT_SAME(a_no_spurious, m_axis_tvalid, pend_reg != 3'd0)
    `LFCI_ASSERT_SAME(a_clear_blocks, !$past(rst_n), !s_axis_tready)
    `LFCI_ASSERT_SAME(a_status_shape, m_axis_tvalid && (m_axis_tdata[33:32] != lfci_pkg::MODE_READ), m_axis_tdata[15:8] == 8'h00)

endmodule

bind linear_flash_command_interface lfci_checker u_lfci_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
